// File: hdl/rrd_pkg.sv
// Package for the raw socket receive deframer.
// Holds item types, phase and event codes, and handshake constants.
// No dependencies.
package rrd_pkg;

    localparam logic [7:0] MAGIC_BYTE   = 8'h7f;
    localparam int         LEN_EXP_BASE = 9;
    localparam logic [3:0] NIBBLE_MASK  = 4'hf;

    // Phase codes
    localparam logic [1:0] PH_HANDSHAKE = 2'd0;
    localparam logic [1:0] PH_PREFIX    = 2'd1;
    localparam logic [1:0] PH_MESSAGE   = 2'd2;
    localparam logic [1:0] PH_HALTED    = 2'd3;

    // Event codes
    localparam logic [2:0] EV_PAYLOAD   = 3'd0;
    localparam logic [2:0] EV_HS_DONE   = 3'd1;
    localparam logic [2:0] EV_EMPTY     = 3'd2;
    localparam logic [2:0] EV_BAD_MAGIC = 3'd3;
    localparam logic [2:0] EV_RESERVED  = 3'd4;
    localparam logic [2:0] EV_BAD_TYPE  = 3'd5;

    // Position codes inside handshake and prefix
    localparam logic [15:0] POS_0 = 16'd0;
    localparam logic [15:0] POS_1 = 16'd1;
    localparam logic [15:0] POS_2 = 16'd2;
    localparam logic [15:0] POS_3 = 16'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic        last;
        logic [3:0]  max_len_exponent;
        logic [3:0]  serializer;
        logic [15:0] message_length;
    } t_res_item;

endpackage

// File: hdl/rrd_in_if.sv
// Input channel of the deframer: valid/ready handshake with one byte item.
// Depends on nothing.
interface rrd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// File: hdl/rrd_out_if.sv
// Result channel of the deframer: valid/ready handshake with one result item.
// Depends on nothing.
interface rrd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic        last;
    logic [3:0]  max_len_exponent;
    logic [3:0]  serializer;
    logic [15:0] message_length;

    modport source (output valid, output event_res, output payload_byte, output last,
                    output max_len_exponent, output serializer, output message_length,
                    input ready);
    modport sink   (input valid, input event_res, input payload_byte, input last,
                    input max_len_exponent, input serializer, input message_length,
                    output ready);
endinterface

// File: hdl/rrd_in_stage.sv
// Input register stage of the deframer.
// Depends on rrd_pkg.
module rrd_in_stage
    import rrd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_ready,
    input  logic     i_out_can,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // Take a new item when empty or when the held item moves on
    assign o_ready = !r_valid || i_out_can;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_out_can) begin
            r_valid <= 1'b0;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hdl/rrd_deframe.sv
// Deframer state and per-byte decision logic.
// Depends on rrd_pkg.
module rrd_deframe
    import rrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_res_item o_res
);

    logic [1:0]  r_phase,        n_phase;
    logic [15:0] r_byte_count,   n_byte_count;
    logic [15:0] r_frame_length, n_frame_length;
    logic [15:0] r_prefix_high,  n_prefix_high;
    logic [7:0]  r_peer,         n_peer;

    logic [2:0]  ev;
    logic [7:0]  pb;
    logic        lst;
    logic [15:0] count_inc;
    logic [7:0]  b;

    assign b         = i_item.data_byte;
    assign count_inc = r_byte_count + 16'd1;

    // Decide next state and result for the held item
    always_comb begin
        n_phase        = r_phase;
        n_byte_count   = r_byte_count;
        n_frame_length = r_frame_length;
        n_prefix_high  = r_prefix_high;
        n_peer         = r_peer;
        o_res_valid    = 1'b0;
        ev             = EV_PAYLOAD;
        pb             = 8'd0;
        lst            = 1'b0;
        if (i_item.kind) begin
            n_phase      = PH_HANDSHAKE;
            n_byte_count = POS_0;
        end else begin
            case (r_phase)
                PH_HANDSHAKE: begin
                    case (r_byte_count)
                        POS_0: begin
                            if (b != MAGIC_BYTE) begin
                                o_res_valid = 1'b1;
                                ev          = EV_BAD_MAGIC;
                            end else begin
                                n_byte_count = POS_1;
                            end
                        end
                        POS_1: begin
                            n_peer       = b;
                            n_byte_count = POS_2;
                        end
                        POS_2: begin
                            if (b != 8'd0) begin
                                n_byte_count = POS_0;
                                o_res_valid  = 1'b1;
                                ev           = EV_RESERVED;
                            end else begin
                                n_byte_count = POS_3;
                            end
                        end
                        default: begin
                            n_byte_count = POS_0;
                            o_res_valid  = 1'b1;
                            if (b != 8'd0) begin
                                ev = EV_RESERVED;
                            end else begin
                                n_phase = PH_PREFIX;
                                ev      = EV_HS_DONE;
                            end
                        end
                    endcase
                end
                PH_PREFIX: begin
                    case (r_byte_count)
                        POS_0: begin
                            n_prefix_high = {b, 8'd0};
                            n_byte_count  = POS_1;
                        end
                        POS_1: begin
                            n_prefix_high = {r_prefix_high[15:8], b};
                            n_byte_count  = POS_2;
                        end
                        POS_2: begin
                            n_frame_length = {b, 8'd0};
                            n_byte_count   = POS_3;
                        end
                        default: begin
                            n_frame_length = {r_frame_length[15:8], b};
                            n_byte_count   = POS_0;
                            if (r_prefix_high != 16'd0) begin
                                n_phase     = PH_HALTED;
                                o_res_valid = 1'b1;
                                ev          = EV_BAD_TYPE;
                            end else if (n_frame_length == 16'd0) begin
                                o_res_valid = 1'b1;
                                ev          = EV_EMPTY;
                            end else begin
                                n_phase = PH_MESSAGE;
                            end
                        end
                    endcase
                end
                PH_MESSAGE: begin
                    // Pass the byte through, mark the final one
                    o_res_valid  = 1'b1;
                    ev           = EV_PAYLOAD;
                    pb           = b;
                    lst          = (count_inc == r_frame_length);
                    n_byte_count = count_inc;
                    if (lst) begin
                        n_phase      = PH_PREFIX;
                        n_byte_count = POS_0;
                    end
                end
                default: begin
                    // Halted: drop bytes until a connection event
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HANDSHAKE;
            r_byte_count   <= 16'd0;
            r_frame_length <= 16'd0;
            r_prefix_high  <= 16'd0;
            r_peer         <= 8'd0;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_byte_count   <= n_byte_count;
            r_frame_length <= n_frame_length;
            r_prefix_high  <= n_prefix_high;
            r_peer         <= n_peer;
        end
    end

    assign o_res.event_res        = ev;
    assign o_res.payload_byte     = pb;
    assign o_res.last             = lst;
    assign o_res.max_len_exponent = n_peer[7:4] & NIBBLE_MASK;
    assign o_res.serializer       = n_peer[3:0] & NIBBLE_MASK;
    assign o_res.message_length   = n_frame_length;

endmodule

// File: hdl/rrd_out_stage.sv
// Result register stage of the deframer.
// Depends on rrd_pkg.
module rrd_out_stage
    import rrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  logic      i_res_valid,
    input  t_res_item i_res,
    output logic      o_can,
    input  logic      i_ready,
    output logic      o_valid,
    output t_res_item o_res
);

    logic      r_valid;
    t_res_item r_res;

    // Free when empty or when the held result is being taken
    assign o_can = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= i_res_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        if (i_fire && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: hdl/rawsocket_receive_deframer_top.sv
// Raw socket receive deframer: handshake check and frame splitting, one byte per item.
// Path: input register, decision logic, result register (when a result item is made).
// Throughput: 1 item per cycle; set by the single decision stage between the
// input and result registers, stalled only by result backpressure.
// Reset: synchronous active low; phase returns to handshake wait, counters clear.
// Depends on rrd_pkg, rrd_in_if, rrd_out_if, rrd_in_stage, rrd_deframe, rrd_out_stage.
module rawsocket_receive_deframer_top
    import rrd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rrd_in_if.sink    i_in,
    rrd_out_if.source o_out
);

    t_in_item  in_item;
    t_in_item  held_item;
    logic      held_valid;
    logic      out_can;
    logic      fire;
    logic      res_valid;
    t_res_item res;
    t_res_item out_res;
    logic      out_valid;

    assign in_item.kind      = i_in.kind;
    assign in_item.data_byte = i_in.data_byte;

    // Advance the held item whenever the result register can take its result
    assign fire = held_valid && out_can;

    rrd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_item    (in_item),
        .o_ready   (i_in.ready),
        .i_out_can (out_can),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    rrd_deframe u_deframe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (held_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rrd_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_can       (out_can),
        .i_ready     (o_out.ready),
        .o_valid     (out_valid),
        .o_res       (out_res)
    );

    assign o_out.valid            = out_valid;
    assign o_out.event_res        = out_res.event_res;
    assign o_out.payload_byte     = out_res.payload_byte;
    assign o_out.last             = out_res.last;
    assign o_out.max_len_exponent = out_res.max_len_exponent;
    assign o_out.serializer       = out_res.serializer;
    assign o_out.message_length   = out_res.message_length;

endmodule
